// ----- rtl/core/baro_sensor_sequencer_compensation_defines.svh -----
// Assertion macros used by the barometer sequencer checker.
// Needs no other file; include by bare file name where assertions are written.
`ifndef BARO_SENSOR_SEQUENCER_COMPENSATION_DEFINES_SVH
`define BARO_SENSOR_SEQUENCER_COMPENSATION_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BSSC_ASSERT_HOLDS(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BSSC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/bssc_pkg.sv -----
// Shared types, codes and widths of the barometer sequencer.
// No dependencies; used by the top level, its checker and the testbench.
`default_nettype none

package bssc_pkg;

  localparam int unsigned IN_TDATA_W  = 56;
  localparam int unsigned OUT_TDATA_W = 48;
  localparam int unsigned CFG_ADDR_W  = 3;
  localparam int unsigned CFG_DATA_W  = 16;

  localparam int unsigned NOW_W  = 32;
  localparam int unsigned ADC_W  = 24;
  localparam int unsigned CAL_W  = 16;
  localparam int unsigned WAIT_W = 8;
  localparam int unsigned TEMP_W = 19;
  localparam int unsigned PRES_W = 23;
  localparam int unsigned CMD_W  = 2;

  // Serial multiplier: multiplicand up to 36 bits signed, multiplier up to 24 bits.
  localparam int unsigned MC_W   = 37;
  localparam int unsigned MR_W   = 24;
  localparam int unsigned CNT_W  = 5;
  localparam int unsigned DT_W   = 25;
  localparam int unsigned COEF_W = 36;
  localparam int unsigned PR_W   = 41;

  localparam logic [CNT_W-1:0] STEPS_CAL  = 5'd16;
  localparam logic [CNT_W-1:0] STEPS_PRES = 5'd24;

  localparam logic [CMD_W-1:0] CMD_NONE        = 2'd0;
  localparam logic [CMD_W-1:0] CMD_PRESSURE    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TEMPERATURE = 2'd2;

  localparam logic [CFG_ADDR_W-1:0] REG_SENS     = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_OFF      = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_TCS      = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_TCO      = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_TREF     = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_TEMPSENS = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] REG_WAIT     = 3'd6;

  localparam logic [WAIT_W-1:0] WAIT_RESET = 8'd9;

  localparam logic signed [52:0]   TEMP_BASE = 53'sd2000;
  localparam logic signed [PR_W-1:0] P_MIN_EXT = -41'sd4194304;
  localparam logic signed [PR_W-1:0] P_MAX_EXT = 41'sd4194303;

  typedef enum logic [2:0] {
    ST_REQ_P  = 3'd0,
    ST_WAIT_P = 3'd1,
    ST_READ_P = 3'd2,
    ST_WAIT_T = 3'd3,
    ST_READ_T = 3'd4
  } stage_e;

  typedef enum logic [3:0] {
    SQ_IDLE,
    SQ_MUL,
    SQ_TEMP,
    SQ_OFF,
    SQ_SENS,
    SQ_PQ,
    SQ_PSUB,
    SQ_PFIN,
    SQ_OUT
  } seq_e;

  typedef enum logic [1:0] {
    MOP_TEMP,
    MOP_OFF,
    MOP_SENS,
    MOP_PRES
  } mul_op_e;

endpackage

`default_nettype wire

// ----- rtl/core/baro_sensor_sequencer_compensation.sv -----
// Barometer conversion sequencer with first-order compensation, top level.
// Depends on bssc_pkg.
//
// Use: firmware sends one poll word per millisecond tick on the slave stream
// (current time and the converter word a read would return now). Each poll
// gives exactly one word on the master stream: the conversion command to
// issue, whether the converter word was consumed, and, on the poll that
// reads temperature, the compensated temperature and pressure (flagged on
// tuser). Calibration goes in through the plain write port; the user writes
// it only while idle, as the block itself does not enforce this. A poll
// that only steps the sequence goes straight to the output step. The
// temperature-read poll runs four shift-and-add products on one serial
// multiplier, one multiplier bit per cycle (16 + 16 + 16 + 24 steps),
// plus seven fix-up steps. One poll is in work at a time; the next poll is
// taken as soon as the result sits in the output register, even if the
// receiver stalls. While the receiver stalls the output word holds and a
// further result waits in the sequencer until the register frees.
// Reset: sequence goes back to the pressure-start step, deadline clears,
// calibration clears and the wait time returns to 9 ms; no output word.
`default_nettype none

module baro_sensor_sequencer_compensation (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // slave stream: [31:0] now_ms, [55:32] adc_word
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [bssc_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  // master stream: [1:0] conv_command, [2] adc_read, [21:3] temperature,
  // [44:22] pressure, [47:45] zero
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [bssc_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
  // master tuser: [0] result_valid
  output logic                                 m_axis_tuser,
  // configuration write port
  input  logic                                 cfg_we_i,
  input  logic [bssc_pkg::CFG_ADDR_W-1:0]      cfg_addr_i,
  input  logic [bssc_pkg::CFG_DATA_W-1:0]      cfg_wdata_i
);

  // calibration and wait registers
  logic [bssc_pkg::CAL_W-1:0]  cal_sens_q, cal_off_q, cal_tcs_q, cal_tco_q;
  logic [bssc_pkg::CAL_W-1:0]  cal_tref_q, cal_tempsens_q;
  logic [bssc_pkg::WAIT_W-1:0] wait_q;

  // sequence control
  bssc_pkg::seq_e    seq_q, seq_d;
  bssc_pkg::stage_e  stage_q, stage_d;
  bssc_pkg::mul_op_e op_q, op_d;
  logic [bssc_pkg::NOW_W-1:0] deadline_q, deadline_d;
  logic [bssc_pkg::CNT_W-1:0] cnt_q, cnt_d;
  logic                       m_valid_q, m_valid_d;

  // datapath
  logic [bssc_pkg::ADC_W-1:0]  praw_q, praw_d;
  logic [bssc_pkg::DT_W-1:0]   dt_q, dt_d;
  logic [bssc_pkg::MC_W-1:0]   hi_q, hi_d;
  logic [bssc_pkg::MR_W-1:0]   lo_q, lo_d;
  logic [bssc_pkg::COEF_W-1:0] off_q, off_d, sens_q, sens_d;
  logic [bssc_pkg::PR_W-1:0]   pr_q, pr_d;

  // pending result fields
  logic [bssc_pkg::CMD_W-1:0]  cmd_q, cmd_d;
  logic                        rd_q, rd_d, vld_q, vld_d;
  logic [bssc_pkg::TEMP_W-1:0] temp_q, temp_d;
  logic [bssc_pkg::PRES_W-1:0] pres_q, pres_d;

  logic [bssc_pkg::OUT_TDATA_W-1:0] m_data_q, m_data_d;
  logic                             m_user_q, m_user_d;

  // combinational helpers
  logic                        in_acc, out_free;
  logic [bssc_pkg::NOW_W-1:0]  now_ms, wait_diff, deadline_next;
  logic [bssc_pkg::ADC_W-1:0]  adc_word;
  logic                        wait_over;
  logic signed [bssc_pkg::MC_W-1:0] mcand, hi_sum;
  logic signed [52:0]          prod_s, t_shr, t_full, o_shr, o_full, s_shr, s_full;
  logic signed [60:0]          prod_l, q_shr, q_full;
  logic signed [bssc_pkg::PR_W-1:0] p_shr, p_full, pr_sub;
  logic                        rnd_t, rnd_o, rnd_s, rnd_q, rnd_p;

  assign now_ms   = s_axis_tdata[31:0];
  assign adc_word = s_axis_tdata[55:32];

  assign s_axis_tready = (seq_q == bssc_pkg::SQ_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_valid_q || m_axis_tready;

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

  // Wait ends at the first poll strictly after the deadline, modulo wrap.
  assign wait_diff     = now_ms - deadline_q;
  assign wait_over     = (wait_diff != '0) && !wait_diff[31];
  assign deadline_next = now_ms + {24'd0, wait_q};

  // Serial multiplier: add the multiplicand when the low bit is set, then
  // shift the whole product right by one.
  assign mcand  = (op_q == bssc_pkg::MOP_PRES) ? $signed({sens_q[35], sens_q})
                                               : $signed({{12{dt_q[24]}}, dt_q});
  assign hi_sum = $signed(hi_q) + (lo_q[0] ? mcand : 37'sd0);

  // 16-step products sit in {hi, lo[23:8]}, 24-step products in {hi, lo}.
  assign prod_s = $signed({hi_q, lo_q[23:8]});
  assign prod_l = $signed({hi_q, lo_q});

  // Divide by a power of two truncating toward zero: arithmetic shift,
  // plus one when negative with a nonzero remainder.
  assign rnd_t  = prod_s[52] && (prod_s[22:0] != '0);
  assign t_shr  = prod_s >>> 23;
  assign t_full = t_shr + bssc_pkg::TEMP_BASE + $signed({52'd0, rnd_t});

  assign rnd_o  = prod_s[52] && (prod_s[5:0] != '0);
  assign o_shr  = prod_s >>> 6;
  assign o_full = o_shr + $signed({20'd0, cal_off_q, 17'd0}) + $signed({52'd0, rnd_o});

  assign rnd_s  = prod_s[52] && (prod_s[6:0] != '0);
  assign s_shr  = prod_s >>> 7;
  assign s_full = s_shr + $signed({21'd0, cal_sens_q, 16'd0}) + $signed({52'd0, rnd_s});

  assign rnd_q  = prod_l[60] && (prod_l[20:0] != '0);
  assign q_shr  = prod_l >>> 21;
  assign q_full = q_shr + $signed({60'd0, rnd_q});

  assign pr_sub = $signed(pr_q) - $signed({{5{off_q[35]}}, off_q});

  assign rnd_p  = pr_q[40] && (pr_q[14:0] != '0);
  assign p_shr  = $signed(pr_q) >>> 15;
  assign p_full = p_shr + $signed({40'd0, rnd_p});

  // Next state of the sequencer.
  always_comb begin
    seq_d = seq_q;
    case (seq_q)
      bssc_pkg::SQ_IDLE: begin
        if (in_acc) begin
          seq_d = (stage_q == bssc_pkg::ST_READ_T) ? bssc_pkg::SQ_MUL : bssc_pkg::SQ_OUT;
        end
      end
      bssc_pkg::SQ_MUL: begin
        if (cnt_q == 5'd1) begin
          case (op_q)
            bssc_pkg::MOP_TEMP: seq_d = bssc_pkg::SQ_TEMP;
            bssc_pkg::MOP_OFF:  seq_d = bssc_pkg::SQ_OFF;
            bssc_pkg::MOP_SENS: seq_d = bssc_pkg::SQ_SENS;
            bssc_pkg::MOP_PRES: seq_d = bssc_pkg::SQ_PQ;
            default:            seq_d = bssc_pkg::SQ_IDLE;
          endcase
        end
      end
      bssc_pkg::SQ_TEMP,
      bssc_pkg::SQ_OFF,
      bssc_pkg::SQ_SENS: seq_d = bssc_pkg::SQ_MUL;
      bssc_pkg::SQ_PQ:   seq_d = bssc_pkg::SQ_PSUB;
      bssc_pkg::SQ_PSUB: seq_d = bssc_pkg::SQ_PFIN;
      bssc_pkg::SQ_PFIN: seq_d = bssc_pkg::SQ_OUT;
      bssc_pkg::SQ_OUT: begin
        if (out_free) begin
          seq_d = bssc_pkg::SQ_IDLE;
        end
      end
      default: seq_d = bssc_pkg::SQ_IDLE;
    endcase
  end

  // Datapath and output values.
  always_comb begin
    stage_d    = stage_q;
    op_d       = op_q;
    deadline_d = deadline_q;
    cnt_d      = cnt_q;
    praw_d     = praw_q;
    dt_d       = dt_q;
    hi_d       = hi_q;
    lo_d       = lo_q;
    off_d      = off_q;
    sens_d     = sens_q;
    pr_d       = pr_q;
    cmd_d      = cmd_q;
    rd_d       = rd_q;
    vld_d      = vld_q;
    temp_d     = temp_q;
    pres_d     = pres_q;
    m_data_d   = m_data_q;
    m_user_d   = m_user_q;
    m_valid_d  = m_valid_q;

    // drop the output word once taken
    if (m_valid_q && m_axis_tready) begin
      m_valid_d = 1'b0;
    end

    case (seq_q)
      bssc_pkg::SQ_IDLE: begin
        if (in_acc) begin
          cmd_d  = bssc_pkg::CMD_NONE;
          rd_d   = 1'b0;
          vld_d  = 1'b0;
          temp_d = '0;
          pres_d = '0;
          case (stage_q)
            bssc_pkg::ST_REQ_P: begin
              cmd_d      = bssc_pkg::CMD_PRESSURE;
              deadline_d = deadline_next;
              stage_d    = bssc_pkg::ST_WAIT_P;
            end
            bssc_pkg::ST_WAIT_P: begin
              if (wait_over) begin
                stage_d = bssc_pkg::ST_READ_P;
              end
            end
            bssc_pkg::ST_READ_P: begin
              praw_d     = adc_word;
              rd_d       = 1'b1;
              cmd_d      = bssc_pkg::CMD_TEMPERATURE;
              deadline_d = deadline_next;
              stage_d    = bssc_pkg::ST_WAIT_T;
            end
            bssc_pkg::ST_WAIT_T: begin
              if (wait_over) begin
                stage_d = bssc_pkg::ST_READ_T;
              end
            end
            bssc_pkg::ST_READ_T: begin
              rd_d    = 1'b1;
              vld_d   = 1'b1;
              stage_d = bssc_pkg::ST_REQ_P;
              // dT = D2 - tref * 256, then start dT * tempsens
              dt_d    = {1'b0, adc_word} - {1'b0, cal_tref_q, 8'd0};
              hi_d    = '0;
              lo_d    = {8'd0, cal_tempsens_q};
              cnt_d   = bssc_pkg::STEPS_CAL;
              op_d    = bssc_pkg::MOP_TEMP;
            end
            default: stage_d = bssc_pkg::ST_REQ_P;
          endcase
        end
      end
      bssc_pkg::SQ_MUL: begin
        hi_d  = hi_sum >>> 1;
        lo_d  = {hi_sum[0], lo_q[23:1]};
        cnt_d = cnt_q - 5'd1;
      end
      bssc_pkg::SQ_TEMP: begin
        temp_d = t_full[18:0];
        hi_d   = '0;
        lo_d   = {8'd0, cal_tco_q};
        cnt_d  = bssc_pkg::STEPS_CAL;
        op_d   = bssc_pkg::MOP_OFF;
      end
      bssc_pkg::SQ_OFF: begin
        off_d = o_full[35:0];
        hi_d  = '0;
        lo_d  = {8'd0, cal_tcs_q};
        cnt_d = bssc_pkg::STEPS_CAL;
        op_d  = bssc_pkg::MOP_SENS;
      end
      bssc_pkg::SQ_SENS: begin
        sens_d = s_full[35:0];
        hi_d   = '0;
        lo_d   = praw_q;
        cnt_d  = bssc_pkg::STEPS_PRES;
        op_d   = bssc_pkg::MOP_PRES;
      end
      bssc_pkg::SQ_PQ:   pr_d = q_full[40:0];
      bssc_pkg::SQ_PSUB: pr_d = pr_sub;
      bssc_pkg::SQ_PFIN: begin
        // clamp pressure to its field
        if (p_full < bssc_pkg::P_MIN_EXT) begin
          pres_d = bssc_pkg::P_MIN_EXT[22:0];
        end else if (p_full > bssc_pkg::P_MAX_EXT) begin
          pres_d = bssc_pkg::P_MAX_EXT[22:0];
        end else begin
          pres_d = p_full[22:0];
        end
      end
      bssc_pkg::SQ_OUT: begin
        if (out_free) begin
          m_data_d  = {3'd0, pres_q, temp_q, rd_q, cmd_q};
          m_user_d  = vld_q;
          m_valid_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Control registers and configuration.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q          <= bssc_pkg::SQ_IDLE;
      stage_q        <= bssc_pkg::ST_REQ_P;
      op_q           <= bssc_pkg::MOP_TEMP;
      deadline_q     <= '0;
      cnt_q          <= '0;
      m_valid_q      <= 1'b0;
      cal_sens_q     <= '0;
      cal_off_q      <= '0;
      cal_tcs_q      <= '0;
      cal_tco_q      <= '0;
      cal_tref_q     <= '0;
      cal_tempsens_q <= '0;
      wait_q         <= bssc_pkg::WAIT_RESET;
    end else begin
      seq_q      <= seq_d;
      stage_q    <= stage_d;
      op_q       <= op_d;
      deadline_q <= deadline_d;
      cnt_q      <= cnt_d;
      m_valid_q  <= m_valid_d;
      if (cfg_we_i) begin
        case (cfg_addr_i)
          bssc_pkg::REG_SENS:     cal_sens_q     <= cfg_wdata_i;
          bssc_pkg::REG_OFF:      cal_off_q      <= cfg_wdata_i;
          bssc_pkg::REG_TCS:      cal_tcs_q      <= cfg_wdata_i;
          bssc_pkg::REG_TCO:      cal_tco_q      <= cfg_wdata_i;
          bssc_pkg::REG_TREF:     cal_tref_q     <= cfg_wdata_i;
          bssc_pkg::REG_TEMPSENS: cal_tempsens_q <= cfg_wdata_i;
          bssc_pkg::REG_WAIT:     wait_q         <= cfg_wdata_i[7:0];
          default: ;
        endcase
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    praw_q   <= praw_d;
    dt_q     <= dt_d;
    hi_q     <= hi_d;
    lo_q     <= lo_d;
    off_q    <= off_d;
    sens_q   <= sens_d;
    pr_q     <= pr_d;
    cmd_q    <= cmd_d;
    rd_q     <= rd_d;
    vld_q    <= vld_d;
    temp_q   <= temp_d;
    pres_q   <= pres_d;
    m_data_q <= m_data_d;
    m_user_q <= m_user_d;
  end

endmodule

`default_nettype wire

// ----- rtl/core/bssc_checker.sv -----
// Port-level checker for the barometer sequencer, bound to the top level.
// Depends on bssc_pkg and baro_sensor_sequencer_compensation_defines.svh.
`default_nettype none
`include "baro_sensor_sequencer_compensation_defines.svh"

module bssc_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             m_axis_tvalid_i,
  input logic                             m_axis_tready_i,
  input logic [bssc_pkg::OUT_TDATA_W-1:0] m_axis_tdata_i,
  input logic                             m_axis_tuser_i
);

  // hold the word while the receiver stalls
  `BSSC_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid_i && !m_axis_tready_i, m_axis_tvalid_i && $stable(m_axis_tdata_i) && $stable(m_axis_tuser_i), "output word changed while stalled")

  // a result comes only from the poll that reads temperature
  `BSSC_ASSERT_HOLDS(a_result_reads, clk_i, rst_ni, m_axis_tvalid_i && m_axis_tuser_i, m_axis_tdata_i[2] && (m_axis_tdata_i[1:0] == bssc_pkg::CMD_NONE), "result without temperature read")

  // no result: temperature and pressure stay zero
  `BSSC_ASSERT_HOLDS(a_fields_zero, clk_i, rst_ni, m_axis_tvalid_i && !m_axis_tuser_i, m_axis_tdata_i[44:3] == '0, "stale fields on a word without result")

  // a pressure start never consumes the converter word
  `BSSC_ASSERT_HOLDS(a_start_no_read, clk_i, rst_ni, m_axis_tvalid_i && (m_axis_tdata_i[1:0] == bssc_pkg::CMD_PRESSURE), !m_axis_tdata_i[2] && !m_axis_tuser_i, "pressure start with read or result")

endmodule

bind baro_sensor_sequencer_compensation bssc_checker u_bssc_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_i (m_axis_tvalid),
  .m_axis_tready_i (m_axis_tready),
  .m_axis_tdata_i  (m_axis_tdata),
  .m_axis_tuser_i  (m_axis_tuser)
);

`default_nettype wire

// ----- verif/tb.sv -----
// Testbench for the barometer conversion sequencer with first-order compensation.
// Depends on bssc_pkg and the baro_sensor_sequencer_compensation top level only.
// A scoreboard class predicts every reply word; plain tasks drive polls and calibration.

module tb;
  import bssc_pkg::*;

  localparam int CLK_PERIOD     = 12;
  localparam int RESET_CYCLES   = 12;
  localparam int TIMEOUT_CYCLES = 1_000_000;
  localparam int PHASES         = 7;
  localparam int PHASE_POLLS    = 100;
  localparam int HOLD_OFF_AT    = 350;  // poll count that triggers the long receiver stall
  localparam int HOLD_OFF_LEN   = 400;
  localparam int DRAIN_CYCLES   = 200;  // well past the compensation latency
  localparam int SHOWN_ERRORS   = 10;

  // Index past the last register; writes to it must be ignored.
  localparam logic [CFG_ADDR_W-1:0] REG_SPARE = 3'd7;

  // One reply word, split into its fields.
  typedef struct packed {
    logic [CMD_W-1:0]         cmd;
    logic                     rd;
    logic                     valid;
    logic signed [TEMP_W-1:0] temp;
    logic signed [PRES_W-1:0] pres;
  } reply_t;

  // Own copy of the sequencer: stage, deadline, latched pressure word and calibration.
  class baro_scoreboard;
    logic [CAL_W-1:0]  sens, off, tcs, tco, tref, tsens;
    logic [WAIT_W-1:0] wait_ms;
    stage_e            stage;
    logic [NOW_W-1:0]  deadline;
    logic [ADC_W-1:0]  p_raw;
    reply_t            replies_due[$];
    int                mismatches;

    function new();
      sens = '0; off = '0; tcs = '0; tco = '0; tref = '0; tsens = '0;
      wait_ms    = WAIT_RESET;
      stage      = ST_REQ_P;
      deadline   = '0;
      p_raw      = '0;
      mismatches = 0;
    endfunction

    function void set_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
      case (idx)
        REG_SENS:     sens    = v;
        REG_OFF:      off     = v;
        REG_TCS:      tcs     = v;
        REG_TCO:      tco     = v;
        REG_TREF:     tref    = v;
        REG_TEMPSENS: tsens   = v;
        REG_WAIT:     wait_ms = v[WAIT_W-1:0];
        default: ;
      endcase
    endfunction

    // First-order compensation; every division truncates toward zero.
    function void compensate(logic [ADC_W-1:0] d2, output logic signed [TEMP_W-1:0] t,
                             output logic signed [PRES_W-1:0] p);
      longint dt, tt, offv, sensv, pv;
      dt    = longint'(d2) - longint'(tref) * 256;
      tt    = 2000 + (dt * longint'(tsens)) / 8388608;
      offv  = longint'(off) * 131072 + (longint'(tco) * dt) / 64;
      sensv = longint'(sens) * 65536 + (longint'(tcs) * dt) / 128;
      pv    = ((longint'(p_raw) * sensv) / 2097152 - offv) / 32768;
      // Clamp pressure to its field; temperature always fits.
      if (pv < -4194304) pv = -4194304;
      if (pv > 4194303) pv = 4194303;
      t = tt[TEMP_W-1:0];
      p = pv[PRES_W-1:0];
    endfunction

    // Advance the sequence by one accepted poll and queue its reply.
    function void take_poll(logic [NOW_W-1:0] now, logic [ADC_W-1:0] adc);
      reply_t                   r;
      logic [NOW_W-1:0]         d;
      logic signed [TEMP_W-1:0] t;
      logic signed [PRES_W-1:0] p;
      r     = '0;
      r.cmd = CMD_NONE;
      // Wait is over once now is strictly later than the deadline, wrap-aware.
      d = now - deadline;
      case (stage)
        ST_REQ_P: begin
          r.cmd    = CMD_PRESSURE;
          deadline = now + {24'd0, wait_ms};
          stage    = ST_WAIT_P;
        end
        ST_WAIT_P: if (d != '0 && !d[NOW_W-1]) stage = ST_READ_P;
        ST_READ_P: begin
          p_raw    = adc;
          r.rd     = 1'b1;
          r.cmd    = CMD_TEMPERATURE;
          deadline = now + {24'd0, wait_ms};
          stage    = ST_WAIT_T;
        end
        ST_WAIT_T: if (d != '0 && !d[NOW_W-1]) stage = ST_READ_T;
        ST_READ_T: begin
          r.rd = 1'b1;
          compensate(adc, t, p);
          r.temp  = t;
          r.pres  = p;
          r.valid = 1'b1;
          stage   = ST_REQ_P;
        end
        default: stage = ST_REQ_P;
      endcase
      replies_due.push_back(r);
    endfunction

    // Compare one accepted reply word with the oldest prediction.
    function void check_reply(logic [OUT_TDATA_W-1:0] data, logic flag);
      reply_t want;
      if (replies_due.size() == 0) begin
        mismatches++;
        if (mismatches <= SHOWN_ERRORS)
          $display("%0t: unexpected word %h (tuser %b) with nothing pending", $time, data, flag);
        return;
      end
      want = replies_due.pop_front();
      if (data[1:0] !== want.cmd || data[2] !== want.rd || flag !== want.valid ||
          data[21:3] !== want.temp || data[44:22] !== want.pres || data[47:45] !== 3'b000) begin
        mismatches++;
        if (mismatches <= SHOWN_ERRORS)
          $display("%0t: mismatch cmd %0d/%0d rd %0d/%0d valid %0d/%0d temp %0d/%0d pres %0d/%0d pad %b",
                   $time, want.cmd, data[1:0], want.rd, data[2], want.valid, flag,
                   want.temp, $signed(data[21:3]), want.pres, $signed(data[44:22]),
                   data[47:45]);
      end
    endfunction

    function int pending();
      return replies_due.size();
    endfunction
  endclass

  logic                   clk           = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tuser;
  logic                   cfg_we_i      = 1'b0;
  logic [CFG_ADDR_W-1:0]  cfg_addr_i    = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata_i   = '0;

  baro_scoreboard   sb;
  int               polls_sent  = 0;
  bit               tx_calm     = 1'b0;
  logic             rx_hold_off = 1'b0;
  logic [NOW_W-1:0] wall_ms     = '0;
  logic [CFG_DATA_W-1:0] cfg [8];

  baro_sensor_sequencer_compensation dut (
    .clk_i         (clk),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // [31:0] now_ms, [55:32] adc_word
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),   // [1:0] cmd, [2] adc_read, [21:3] temp, [44:22] pres
    .m_axis_tuser  (m_axis_tuser),   // [0] result_valid
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Mostly short gaps, now and then a long one.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Calibration word biased toward the extremes.
  function automatic logic [CFG_DATA_W-1:0] cal_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 20) return '0;
    if (r < 40) return '1;
    return CFG_DATA_W'($urandom_range(0, 65535));
  endfunction

  // Offer one poll word, hold it until accepted, then maybe drop valid for a gap.
  task automatic send_poll(input logic [NOW_W-1:0] now, input logic [ADC_W-1:0] adc);
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {adc, now};
    do @(posedge clk); while (!s_axis_tready);
    sb.take_poll(now, adc);
    polls_sent++;
    gap = tx_calm ? 0 : idle_len();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stop offering and wait until every predicted word has come back.
  task automatic quiesce();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Write all eight indices, the spare one included, one per cycle.
  task automatic program_regs(input logic [CFG_DATA_W-1:0] vals [8]);
    for (int i = 0; i < 8; i++) begin
      cfg_we_i    <= 1'b1;
      cfg_addr_i  <= CFG_ADDR_W'(i);
      cfg_wdata_i <= vals[i];
      @(posedge clk);
      sb.set_reg(CFG_ADDR_W'(i), vals[i]);
    end
    cfg_we_i <= 1'b0;
  endtask

  task automatic run_directed();
    // Reset calibration (all zero, 9 ms wait); deadline wraps past zero.
    send_poll(32'hFFFF_FFFA, 24'h000000);
    send_poll(32'd3, 24'h123456);          // equal to deadline: keep waiting
    send_poll(32'd4, 24'h654321);          // one past deadline: wait over
    send_poll(32'd5, 24'hFFFFFF);          // latch pressure, deadline 14
    send_poll(32'h8000_000E, 24'h000000);  // exactly half the range ahead: not later
    send_poll(32'h8000_000D, 24'h000000);  // just under half the range: later
    send_poll(32'h8000_000D, 24'h800000);  // read temperature with zero calibration
    quiesce();

    // Every register at its top value; the wait masks to 255 ms.
    foreach (cfg[i]) cfg[i] = '1;
    program_regs(cfg);
    send_poll(32'd0, 24'h000000);
    send_poll(32'd255, 24'h000000);
    send_poll(32'd256, 24'h000000);
    send_poll(32'd256, 24'hFFFFFF);
    send_poll(32'd512, 24'h000000);
    send_poll(32'd512, 24'h000000);        // coldest reading against top calibration
    send_poll(32'd1000, 24'hFFFFFF);
    send_poll(32'd1256, 24'hFFFFFF);
    send_poll(32'd1256, 24'h000000);
    send_poll(32'd2000, 24'h000000);
    send_poll(32'd2000, 24'hFFFFFF);
    quiesce();

    // Zero wait, large sensitivity terms, zero offset and reference.
    cfg[REG_SENS]     = '1;
    cfg[REG_OFF]      = '0;
    cfg[REG_TCS]      = '1;
    cfg[REG_TCO]      = '0;
    cfg[REG_TREF]     = '0;
    cfg[REG_TEMPSENS] = '1;
    cfg[REG_WAIT]     = '0;
    cfg[REG_SPARE]    = '0;
    program_regs(cfg);
    send_poll(32'd100, 24'h000000);
    send_poll(32'd100, 24'h000000);        // zero wait still needs a strictly later time
    send_poll(32'd101, 24'h000000);
    send_poll(32'd101, 24'hFFFFFF);
    send_poll(32'd102, 24'h000000);
    send_poll(32'd102, 24'hFFFFFF);
    wall_ms = 32'd102;
  endtask

  // Drive the block: reset, directed polls, then random phases with fresh calibration.
  initial begin : stimulus
    int r;
    sb = new();
    repeat (RESET_CYCLES) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);
    run_directed();

    for (int phase = 0; phase < PHASES; phase++) begin
      quiesce();
      for (int i = 0; i < 6; i++) cfg[i] = cal_value();
      r = $urandom_range(0, 99);
      if (r < 15)      cfg[REG_WAIT] = '0;
      else if (r < 25) cfg[REG_WAIT] = {8'($urandom_range(0, 255)), 8'hFF};
      else if (r < 35) cfg[REG_WAIT] = CFG_DATA_W'($urandom_range(0, 65535));
      else             cfg[REG_WAIT] = CFG_DATA_W'($urandom_range(1, 12));
      cfg[REG_SPARE] = CFG_DATA_W'($urandom_range(0, 65535));
      program_regs(cfg);
      tx_calm = (phase == 3);

      for (int n = 0; n < PHASE_POLLS; n++) begin
        // Mostly let time creep forward so sequences complete; sometimes hit the
        // deadline edges, repeat a time, or jump anywhere.
        r = $urandom_range(0, 99);
        if (r < 7)       wall_ms = sb.deadline + $urandom_range(0, 1);
        else if (r < 11) wall_ms = sb.deadline + 32'h8000_0000 - $urandom_range(0, 1);
        else if (r < 16) wall_ms = $urandom();
        else if (r >= 22) wall_ms = wall_ms + $urandom_range(0, sb.wait_ms / 3 + 2);
        r = $urandom_range(0, 99);
        if (r < 8)       send_poll(wall_ms, 24'h000000);
        else if (r < 16) send_poll(wall_ms, 24'hFFFFFF);
        else             send_poll(wall_ms, ADC_W'($urandom()));
      end
    end

    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Receiver: random stalls, calm stretches, and the forced hold-off.
  initial begin : rx_side
    int hold;
    bit calm;
    hold = 0;
    calm = 1'b0;
    forever begin
      @(posedge clk);
      if ($urandom_range(0, 999) == 0) calm = !calm;
      if (rx_hold_off || hold > 0) begin
        m_axis_tready <= 1'b0;
        if (hold > 0) hold--;
      end else begin
        m_axis_tready <= 1'b1;
        if (!calm) hold = idle_len();
      end
    end
  end

  // Hold the receiver off long enough that the block fills and stalls its input.
  initial begin : rx_hold_off_ctl
    wait (polls_sent >= HOLD_OFF_AT);
    @(posedge clk);
    rx_hold_off <= 1'b1;
    repeat (HOLD_OFF_LEN) @(posedge clk);
    rx_hold_off <= 1'b0;
  end

  // Check every reply word accepted by the receiver.
  always @(posedge clk) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_reply(m_axis_tdata, m_axis_tuser);
  end

  initial begin : watchdog
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ----- baro_sensor_sequencer_compensation.f -----
+incdir+rtl/core
rtl/core/bssc_pkg.sv
rtl/core/baro_sensor_sequencer_compensation.sv
rtl/core/bssc_checker.sv
verif/tb.sv
